// ===== rtl/core/rtp_nal_pkg.sv =====
`timescale 1ns / 1ps

package rtp_nal_pkg;

   // Largest RTP packet on the wire, header included.
   localparam int MAX_PACKET_BYTES = 1500;
   localparam int RTP_HEADER_BYTES = 12;
   localparam int PAYLOAD_CAP      = MAX_PACKET_BYTES - RTP_HEADER_BYTES;

   localparam int CSR_ADDR_WIDTH = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_PAYLOAD_TYPE     = 2'd0;
   localparam logic [1:0] REG_SOURCE_ID        = 2'd1;
   localparam logic [1:0] REG_MAX_PAYLOAD      = 2'd2;
   localparam logic [1:0] REG_INITIAL_SEQUENCE = 2'd3;

   localparam logic [6:0]  PAYLOAD_TYPE_RESET = 7'd96;
   localparam logic [10:0] MAX_PAYLOAD_RESET  = 11'd1400;
   localparam logic [10:0] MAX_PAYLOAD_FLOOR  = 11'd3;

   // Fixed byte values of the packet format.
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] FU_START_BIT     = 8'h80;
   localparam logic [7:0] FU_END_BIT       = 8'h40;
   localparam logic [7:0] FU_A_TYPE        = 8'd28;
   localparam logic [7:0] NAL_TYPE_MASK    = 8'h1F;
   localparam logic [7:0] NAL_NRI_MASK     = 8'hE0;
   localparam logic [7:0] NAL_SEI          = 8'h06;
   localparam logic [7:0] NAL_SPS          = 8'h67;
   localparam logic [7:0] NAL_PPS          = 8'h68;

   typedef struct packed {
      logic [7:0]  nal_byte;
      logic [15:0] nal_length;
      logic [31:0] frame_time;
      logic        first_of_nal;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       packet_start;
      logic       packet_end;
      logic       last_of_run;
   } rsp_payload_type;

   // Per-job fields for emitting the bytes caused by one input byte.
   typedef struct packed {
      logic        with_header;
      logic        with_fu;
      logic        marker;
      logic [15:0] seq_number;
      logic [31:0] stamp;
      logic [7:0]  fu_indicator;
      logic [7:0]  fu_header;
      logic [7:0]  data;
      logic        data_end;
   } job_type;

endpackage

// ===== rtl/core/rtp_h264_nal_packetizer_top.sv =====
`timescale 1ns / 1ps

// RTP packetizer for H.264 NAL units, single NAL unit and FU-A modes.
// The req channel carries one NAL byte per beat, header byte first and flagged
// by first_of_nal; that beat also carries the unit length and RTP timestamp.
// The rsp channel carries the RTP packet stream one byte per beat, with flags
// for the first and final byte of each packet and for the last byte caused by
// a given input beat. The APB-style port holds payload type, SSRC, maximum
// payload and the initial sequence number; the user must write it only while
// idle, since the block itself does not enforce that. Each accepted byte is
// decoded in the cycle it is accepted into a job register, and a byte counter
// walks that job onto the registered rsp output. Throughput is one input beat
// per cycle for payload bytes while the receiver keeps up. A beat that opens
// a packet causes 13 output beats (15 for an FU-A fragment), so req_ready
// drops while the job counter walks that header burst through the single
// output register.
// When the receiver stalls, the output register holds its beat, the job
// counter stops and req_ready falls once the pending job cannot retire.
// Synchronous reset clears the handshake state and the unit tracking state,
// and loads the register reset values: payload type 96, SSRC 0, maximum
// payload 1400, sequence counter 0.

module rtp_h264_nal_packetizer_top
   import rtp_nal_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // Configuration registers.
   logic [6:0]  payload_type_ff;
   logic [31:0] source_id_ff;
   logic [10:0] max_payload_ff;
   logic [15:0] initial_sequence_ff;

   // Unit tracking state.
   logic [15:0] sequence_ff,  sequence_in;
   logic [15:0] position_ff,  position_in;
   logic [10:0] fill_ff,      fill_in;
   logic [7:0]  header_ff,    header_in;
   logic [15:0] length_ff,    length_in;
   logic [31:0] time_ff,      time_in;
   logic        frag_mode_ff, frag_mode_in;

   // Job register and emission counter.
   job_type     job_ff,       job_in;
   logic        job_valid_ff;
   logic        job_load;
   logic [3:0]  index_ff;
   logic [3:0]  index_last;
   logic        index_done;

   // Output register.
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff;
   logic            advance;

   logic        req_accept;
   logic        csr_write;
   logic [1:0]  csr_index;

   logic [10:0] eff_max;
   logic [10:0] frag_size;
   logic [15:0] first_length;
   logic        unit_active;
   logic        unit_end;
   logic [15:0] remaining;
   logic        last_frag;
   logic [10:0] fill_plus;
   logic        frag_close;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      case (csr_index)
         REG_PAYLOAD_TYPE:     prdata = {25'd0, payload_type_ff};
         REG_SOURCE_ID:        prdata = source_id_ff;
         REG_MAX_PAYLOAD:      prdata = {21'd0, max_payload_ff};
         REG_INITIAL_SEQUENCE: prdata = {16'd0, initial_sequence_ff};
         default:              prdata = 32'd0;
      endcase
   end

   // Payload size limits: the register is clamped to a usable range.
   always_comb begin
      eff_max = max_payload_ff;
      if (max_payload_ff < MAX_PAYLOAD_FLOOR) begin
         eff_max = MAX_PAYLOAD_FLOOR;
      end
      if (32'(max_payload_ff) > PAYLOAD_CAP) begin
         eff_max = 11'(PAYLOAD_CAP);
      end
      frag_size = eff_max - 11'd2;
   end

   // Handshakes. A job retires when its final byte moves to the output
   // register; the next input byte may be taken in that same cycle.
   assign advance    = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign index_last = job_ff.with_header ? (job_ff.with_fu ? 4'd14 : 4'd12) : 4'd0;
   assign index_done = (index_ff == index_last);
   assign req_ready  = !job_valid_ff || (advance && index_done);
   assign req_accept = req_valid && req_ready;

   // Decode of one input byte against the unit state.
   assign first_length = (req_payload.nal_length == 16'd0) ? 16'd1 : req_payload.nal_length;
   assign unit_active  = (position_ff < length_ff);
   assign unit_end     = (position_ff == (length_ff - 16'd1));
   assign remaining    = length_ff - position_ff;
   assign last_frag    = (remaining <= {5'd0, frag_size});
   assign fill_plus    = fill_ff + 11'd1;
   assign frag_close   = (fill_plus >= frag_size) || unit_end;

   always_comb begin
      sequence_in  = sequence_ff;
      position_in  = position_ff;
      fill_in      = fill_ff;
      header_in    = header_ff;
      length_in    = length_ff;
      time_in      = time_ff;
      frag_mode_in = frag_mode_ff;
      job_load     = 1'b0;

      job_in              = job_ff;
      job_in.with_header  = 1'b0;
      job_in.with_fu      = 1'b0;
      job_in.marker       = 1'b0;
      job_in.seq_number   = sequence_ff;
      job_in.stamp        = time_ff;
      job_in.fu_indicator = (header_ff & NAL_NRI_MASK) | FU_A_TYPE;
      job_in.fu_header    = header_ff & NAL_TYPE_MASK;
      job_in.data         = req_payload.nal_byte;
      job_in.data_end     = 1'b0;

      if (req_payload.first_of_nal) begin
         header_in    = req_payload.nal_byte;
         length_in    = first_length;
         time_in      = req_payload.frame_time;
         fill_in      = 11'd0;
         position_in  = 16'd1;
         frag_mode_in = (first_length > {5'd0, eff_max});
         if (!frag_mode_in) begin
            // Whole unit in one packet; header bytes equal to NAL_SEI, NAL_SPS or NAL_PPS carry no marker.
            job_load           = 1'b1;
            job_in.with_header = 1'b1;
            job_in.marker      = !(req_payload.nal_byte == NAL_SEI ||
                                   req_payload.nal_byte == NAL_SPS ||
                                   req_payload.nal_byte == NAL_PPS);
            job_in.stamp       = req_payload.frame_time;
            job_in.data_end    = (first_length == 16'd1);
            sequence_in        = sequence_ff + 16'd1;
         end
      end else if (unit_active) begin
         job_load    = 1'b1;
         position_in = position_ff + 16'd1;
         if (!frag_mode_ff) begin
            job_in.data_end = unit_end;
         end else begin
            if (fill_ff == 11'd0) begin
               // This byte opens a fragment: RTP header plus the FU bytes.
               job_in.with_header = 1'b1;
               job_in.with_fu     = 1'b1;
               job_in.marker      = last_frag;
               job_in.fu_header   = (header_ff & NAL_TYPE_MASK)
                                  | ((position_ff == 16'd1) ? FU_START_BIT : 8'd0)
                                  | (last_frag ? FU_END_BIT : 8'd0);
               sequence_in        = sequence_ff + 16'd1;
            end
            job_in.data_end = frag_close;
            fill_in         = frag_close ? 11'd0 : fill_plus;
         end
      end
   end

   // Byte selection for the current position within the job.
   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.packet_start = 1'b0;
      rsp_in.packet_end   = 1'b0;
      rsp_in.last_of_run  = index_done;
      rsp_in.packet_byte  = job_ff.data;
      if (!job_ff.with_header) begin
         rsp_in.packet_end = job_ff.data_end;
      end else begin
         case (index_ff)
            4'd0: begin
               rsp_in.packet_byte  = RTP_VERSION_BYTE;
               rsp_in.packet_start = 1'b1;
            end
            4'd1:  rsp_in.packet_byte = {job_ff.marker, payload_type_ff};
            4'd2:  rsp_in.packet_byte = job_ff.seq_number[15:8];
            4'd3:  rsp_in.packet_byte = job_ff.seq_number[7:0];
            4'd4:  rsp_in.packet_byte = job_ff.stamp[31:24];
            4'd5:  rsp_in.packet_byte = job_ff.stamp[23:16];
            4'd6:  rsp_in.packet_byte = job_ff.stamp[15:8];
            4'd7:  rsp_in.packet_byte = job_ff.stamp[7:0];
            4'd8:  rsp_in.packet_byte = source_id_ff[31:24];
            4'd9:  rsp_in.packet_byte = source_id_ff[23:16];
            4'd10: rsp_in.packet_byte = source_id_ff[15:8];
            4'd11: rsp_in.packet_byte = source_id_ff[7:0];
            4'd12: begin
               if (job_ff.with_fu) begin
                  rsp_in.packet_byte = job_ff.fu_indicator;
               end else begin
                  rsp_in.packet_end = job_ff.data_end;
               end
            end
            4'd13: rsp_in.packet_byte = job_ff.fu_header;
            default: rsp_in.packet_end = job_ff.data_end;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_type_ff     <= PAYLOAD_TYPE_RESET;
         source_id_ff        <= 32'd0;
         max_payload_ff      <= MAX_PAYLOAD_RESET;
         initial_sequence_ff <= 16'd0;
         sequence_ff         <= 16'd0;
         position_ff         <= 16'd0;
         fill_ff             <= 11'd0;
         header_ff           <= 8'd0;
         length_ff           <= 16'd0;
         time_ff             <= 32'd0;
         frag_mode_ff        <= 1'b0;
         job_valid_ff        <= 1'b0;
         index_ff            <= 4'd0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         // A write of the initial sequence register loads the counter.
         if (csr_write && (csr_index == REG_INITIAL_SEQUENCE)) begin
            sequence_ff <= pwdata[15:0];
         end else if (req_accept) begin
            sequence_ff <= sequence_in;
         end

         if (req_accept) begin
            position_ff  <= position_in;
            fill_ff      <= fill_in;
            header_ff    <= header_in;
            length_ff    <= length_in;
            time_ff      <= time_in;
            frag_mode_ff <= frag_mode_in;
         end

         if (advance) begin
            index_ff <= index_done ? 4'd0 : index_ff + 4'd1;
         end
         if (req_accept) begin
            job_valid_ff <= job_load;
         end else if (advance && index_done) begin
            job_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write) begin
            case (csr_index)
               REG_PAYLOAD_TYPE:     payload_type_ff     <= pwdata[6:0];
               REG_SOURCE_ID:        source_id_ff        <= pwdata;
               REG_MAX_PAYLOAD:      max_payload_ff      <= pwdata[10:0];
               REG_INITIAL_SEQUENCE: initial_sequence_ff <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && job_load) begin
         job_ff <= job_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Every packet opens with the RTP version byte.
   a_start_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.packet_start |-> rsp_ff.packet_byte == RTP_VERSION_BYTE)
      else $error("packet start without version byte");

   // The emission counter never runs past the end of its job.
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> index_ff <= index_last)
      else $error("job byte counter out of range");

   // The unit position never passes the unit length.
   a_position: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> position_ff <= length_ff)
      else $error("unit position beyond unit length");

   // A fragment fill always stays below the payload cap.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) < PAYLOAD_CAP)
      else $error("fragment fill out of range");

endmodule

// ===== verif/rtp_stream_check_pkg.sv =====
`timescale 1ns / 1ps

package rtp_stream_check_pkg;
   import rtp_nal_pkg::*;

   // Tracks the packetizer's registers and unit state, works out the packet
   // bytes each NAL byte must produce and checks the output against them.
   class rtp_stream_checker;
      bit [6:0]  pt;
      bit [31:0] ssrc;
      bit [10:0] max_pl;

      bit [15:0] seq_next;
      bit [15:0] taken;
      bit [10:0] fill;
      bit [7:0]  nal_hdr;
      bit [15:0] nal_len;
      bit [31:0] stamp;
      bit        fragmenting;

      rsp_payload_type expected_bytes[$];
      rsp_payload_type run_bytes[$];
      int errors;
      int checked;

      function new();
         pt          = PAYLOAD_TYPE_RESET;
         ssrc        = '0;
         max_pl      = MAX_PAYLOAD_RESET;
         seq_next    = '0;
         taken       = '0;
         fill        = '0;
         nal_hdr     = '0;
         nal_len     = '0;
         stamp       = '0;
         fragmenting = 1'b0;
         errors      = 0;
         checked     = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_PAYLOAD_TYPE:     pt = value[6:0];
            REG_SOURCE_ID:        ssrc = value;
            REG_MAX_PAYLOAD:      max_pl = value[10:0];
            REG_INITIAL_SEQUENCE: seq_next = value[15:0];
            default: ;
         endcase
      endfunction

      function int payload_limit();
         int m;
         m = max_pl;
         if (m < MAX_PAYLOAD_FLOOR) m = MAX_PAYLOAD_FLOOR;
         if (m > PAYLOAD_CAP) m = PAYLOAD_CAP;
         return m;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void add_byte(logic [7:0] value, bit opening, bit closing);
         rsp_payload_type e;
         e.packet_byte  = value;
         e.packet_start = opening;
         e.packet_end   = closing;
         e.last_of_run  = 1'b0;
         run_bytes.push_back(e);
      endfunction

      function void add_header(bit marker);
         bit [15:0] seq_now;
         seq_now  = seq_next;
         seq_next = seq_next + 16'd1;
         add_byte(RTP_VERSION_BYTE, 1'b1, 1'b0);
         add_byte({marker, pt}, 1'b0, 1'b0);
         add_byte(seq_now[15:8], 1'b0, 1'b0);
         add_byte(seq_now[7:0], 1'b0, 1'b0);
         add_byte(stamp[31:24], 1'b0, 1'b0);
         add_byte(stamp[23:16], 1'b0, 1'b0);
         add_byte(stamp[15:8], 1'b0, 1'b0);
         add_byte(stamp[7:0], 1'b0, 1'b0);
         add_byte(ssrc[31:24], 1'b0, 1'b0);
         add_byte(ssrc[23:16], 1'b0, 1'b0);
         add_byte(ssrc[15:8], 1'b0, 1'b0);
         add_byte(ssrc[7:0], 1'b0, 1'b0);
      endfunction

      function void note_nal_byte(req_payload_type item);
         rsp_payload_type e;
         bit ending;
         bit final_fragment;
         bit marker;
         int frag_size;
         logic [7:0] fu_hdr;
         run_bytes.delete();
         if (item.first_of_nal) begin
            nal_len     = (item.nal_length == 16'd0) ? 16'd1 : item.nal_length;
            nal_hdr     = item.nal_byte;
            stamp       = item.frame_time;
            fill        = '0;
            taken       = 16'd1;
            fragmenting = int'(nal_len) > payload_limit();
            if (!fragmenting) begin
               marker = !(item.nal_byte == NAL_SEI || item.nal_byte == NAL_SPS ||
                          item.nal_byte == NAL_PPS);
               add_header(marker);
               add_byte(item.nal_byte, 1'b0, nal_len == 16'd1);
            end
         end else if (taken < nal_len) begin
            ending = (taken == nal_len - 16'd1);
            if (!fragmenting) begin
               add_byte(item.nal_byte, 1'b0, ending);
            end else begin
               frag_size = payload_limit() - 2;
               // Each fragment opens with RTP header, FU indicator and FU header.
               if (fill == 0) begin
                  final_fragment = (int'(nal_len) - int'(taken)) <= frag_size;
                  fu_hdr = nal_hdr & NAL_TYPE_MASK;
                  if (taken == 16'd1) fu_hdr = fu_hdr | FU_START_BIT;
                  if (final_fragment) fu_hdr = fu_hdr | FU_END_BIT;
                  add_header(final_fragment);
                  add_byte((nal_hdr & NAL_NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0);
                  add_byte(fu_hdr, 1'b0, 1'b0);
               end
               fill = fill + 11'd1;
               if (int'(fill) >= frag_size || ending) begin
                  add_byte(item.nal_byte, 1'b0, 1'b1);
                  fill = '0;
               end else begin
                  add_byte(item.nal_byte, 1'b0, 1'b0);
               end
            end
            taken = taken + 16'd1;
         end
         foreach (run_bytes[i]) begin
            e = run_bytes[i];
            if (i == run_bytes.size() - 1) e.last_of_run = 1'b1;
            expected_bytes.push_back(e);
         end
      endfunction

      function void flag(string field, int want, int got);
         $display("%0t: packet byte %0d, %s expected %0h, got %0h",
                  $time, checked, field, want, got);
         errors++;
      endfunction

      function void check_packet_byte(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected packet byte, expected none, got %h", $time, got);
            errors++;
         end else begin
            want = expected_bytes.pop_front();
            if (got.packet_byte !== want.packet_byte)
               flag("packet_byte", want.packet_byte, got.packet_byte);
            if (got.packet_start !== want.packet_start)
               flag("packet_start", want.packet_start, got.packet_start);
            if (got.packet_end !== want.packet_end)
               flag("packet_end", want.packet_end, got.packet_end);
            if (got.last_of_run !== want.last_of_run)
               flag("last_of_run", want.last_of_run, got.last_of_run);
         end
         checked++;
      endfunction
   endclass

endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import rtp_nal_pkg::*;
   import rtp_stream_check_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_payload_type           req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_payload_type           rsp_payload;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   // Chance, in percent, that the sender or the receiver idles on a cycle.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // Set by the stimulus to request a receiver hold-off; the value is in clock cycles.
   int hold_cycles = 0;

   rtp_stream_checker sb;

   rtp_h264_nal_packetizer_top uut (.*);

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard ceiling on the run. The slowest correct run is far below this: a
   // few hundred accepted beats, each causing at most 15 packet bytes, with
   // the receiver idling 84 percent of the time in one phase.
   initial begin
      #4_000_000;
      $display("[rtp_h264_nal_packetizer_top] ERROR");
      $finish;
   end

   // Receiver. Ready is redrawn every falling edge, except while a requested
   // hold-off runs; the hold-off is counted here so the sender keeps offering
   // beats meanwhile and the block has to back up onto its input.
   initial begin
      int stretch;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            stretch = hold_cycles;
            hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (stretch - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Every output beat taken by the receiver is checked against the oldest
   // expected packet byte.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_packet_byte(rsp_payload);
   end

   // Holds the sender back until every expected packet byte has come, so
   // nothing is in flight, then writes one register through a setup phase and an
   // access phase. The checker's copy changes at the very edge at which the
   // block takes the write. The bus then goes idle before the task returns.
   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'({index, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_register(index, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Offers one NAL byte and returns at the falling edge after its beat is
   // taken. Valid is only lowered when the sender decides to idle, so back to
   // back beats never see valid dropped and raised in the same time step.
   task automatic offer_nal_byte(input logic [7:0] data, input logic [15:0] length,
                                 input logic [31:0] stamp, input logic first);
      req_payload_type beat;
      beat.nal_byte     = data;
      beat.nal_length   = length;
      beat.frame_time   = stamp;
      beat.first_of_nal = first;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_nal_byte(beat);
      @(negedge clock);
   endtask

   // Sends the header byte of a unit with the given length field, then
   // random payload bytes until count bytes have gone. A count short of the
   // length leaves the unit open, to be cut off by the next header byte.
   // Length and timestamp on payload bytes are junk the block must ignore.
   task automatic send_unit(input logic [7:0] hdr, input int length, input int count,
                            input logic [31:0] stamp);
      offer_nal_byte(hdr, length[15:0], stamp, 1'b1);
      repeat (count - 1) offer_nal_byte(8'($urandom), 16'($urandom), $urandom, 1'b0);
   endtask

   // Holds the sender back until every expected packet byte has come, then
   // keeps waiting with the sender idle before it returns, since header bytes of
   // fragmented units cause no output and do not show among the expected bytes.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Random stream of NAL units. Most are complete and short, so both the
   // single packet and the fragmented paths are reached with small register
   // settings. Some are cut short by the next unit, a few carry huge length
   // fields, and now and then a stray byte with no header is thrown in.
   task automatic random_units(input int count);
      int sent;
      int pick;
      int length;
      int unit_bytes;
      logic [7:0] hdr;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            offer_nal_byte(8'($urandom), 16'($urandom), $urandom, 1'b0);
         end else begin
            case ($urandom_range(9))
               0: hdr = NAL_SEI;
               1: hdr = NAL_SPS;
               2: hdr = NAL_PPS;
               default: hdr = 8'($urandom);
            endcase
            length = ($urandom_range(9) == 0) ? $urandom_range(65535, 0)
                                              : $urandom_range(40, 1);
            unit_bytes = (length == 0) ? 1 : length;
            if (unit_bytes > 40) unit_bytes = $urandom_range(40, 1);
            else if (pick < 16) unit_bytes = $urandom_range(unit_bytes, 1);
            send_unit(hdr, length, unit_bytes, $urandom);
            sent += unit_bytes;
         end
      end
   endtask

   initial begin
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, no idling. Extreme register values first: the payload
      // type and SSRC all ones, a maximum payload below the floor so that
      // fragments carry a single byte, and a sequence start just short of
      // the wrap.
      write_csr(REG_PAYLOAD_TYPE, 32'd127);
      write_csr(REG_SOURCE_ID, 32'hFFFF_FFFF);
      write_csr(REG_MAX_PAYLOAD, 32'd0);
      write_csr(REG_INITIAL_SEQUENCE, 32'h0000_FFFE);
      // A stray byte with no unit open must be dropped.
      offer_nal_byte(8'hA5, 16'h1234, 32'h0, 1'b0);
      // One byte parameter set unit, marker clear.
      send_unit(NAL_SPS, 1, 1, 32'h0000_0000);
      // A zero length is taken as one; SEI also clears the marker.
      send_unit(NAL_SEI, 0, 1, 32'hFFFF_FFFF);
      // Exactly the maximum payload still goes out whole.
      send_unit(8'h00, 3, 3, $urandom);
      send_unit(NAL_PPS, 2, 2, $urandom);
      // One past it splits into one byte fragments; the header byte itself
      // produces nothing.
      send_unit(8'h65, 4, 4, $urandom);
      // Another stray byte, after the unit has completed.
      offer_nal_byte(8'h5A, 16'h0000, 32'h0, 1'b0);
      // A unit with the largest length field, left open ...
      send_unit(8'hFF, 16'hFFFF, 3, $urandom);
      // ... and cut off by a new one, which stops with a fragment half full.
      write_csr(REG_MAX_PAYLOAD, 32'd6);
      send_unit(8'h7C, 16'hFFFF, 3, $urandom);
      settle();
      // Shrinking the fragment size under an open fragment closes it on the
      // next byte; the following byte opens a fragment of the new size.
      write_csr(REG_MAX_PAYLOAD, 32'd4);
      offer_nal_byte(8'($urandom), 16'($urandom), $urandom, 1'b0);
      offer_nal_byte(8'($urandom), 16'($urandom), $urandom, 1'b0);
      // That open fragment is abandoned without a packet end.
      send_unit(8'h41, 5, 5, $urandom);
      settle();

      // Random phase one: slow receiver, mostly busy sender.
      send_idle_pct = 17;
      recv_idle_pct = 84;
      write_csr(REG_PAYLOAD_TYPE, 32'd0);
      write_csr(REG_SOURCE_ID, $urandom);
      write_csr(REG_MAX_PAYLOAD, $urandom_range(12, 3));
      write_csr(REG_INITIAL_SEQUENCE, 32'd0);
      random_units(35);
      settle();

      // Random phase two: slow sender, mostly ready receiver. Maximum payload
      // values of one and two act as the floor.
      send_idle_pct = 84;
      recv_idle_pct = 17;
      write_csr(REG_PAYLOAD_TYPE, $urandom_range(127, 0));
      write_csr(REG_SOURCE_ID, 32'd0);
      write_csr(REG_MAX_PAYLOAD, $urandom_range(16, 1));
      write_csr(REG_INITIAL_SEQUENCE, $urandom_range(65535, 0));
      random_units(35);
      settle();

      // Random phase three: no idling at all, and a long receiver hold-off at
      // the start so the block backs up and stalls its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(REG_PAYLOAD_TYPE, $urandom_range(127, 0));
      write_csr(REG_SOURCE_ID, $urandom);
      write_csr(REG_MAX_PAYLOAD, $urandom_range(20, 4));
      write_csr(REG_INITIAL_SEQUENCE, 32'h0000_FFFF);
      hold_cycles = 80;
      random_units(35);
      settle();

      // A maximum payload above the cap acts as the cap, so a unit one byte
      // longer than the cap is fragmented. A few bytes show the first
      // fragment opening without the end bit; the unit is then left open.
      write_csr(REG_MAX_PAYLOAD, 32'd2047);
      send_unit(8'h65, PAYLOAD_CAP + 1, 4, $urandom);
      settle();

      // A maximum payload of 1460, below the cap; every unit whose length field
      // is at most 1460 goes out whole.
      write_csr(REG_MAX_PAYLOAD, 32'd1460);
      random_units(10);

      // Wind down: let the last packet bytes drain, then watch a little longer
      // for anything extra.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected packet bytes never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("[rtp_h264_nal_packetizer_top] OK");
      end else begin
         $display("[rtp_h264_nal_packetizer_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rtp_nal_pkg.sv
rtl/core/rtp_h264_nal_packetizer_top.sv
verif/rtp_stream_check_pkg.sv
verif/testbench.sv
